// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish in synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/udlc_pkg.sv
// ---------------------------------------------------------------------------
// udlc_pkg
// shared types, line type codes, prefix table and character constants
// ---------------------------------------------------------------------------
package udlc_pkg;

  localparam logic [3:0] LT_DEFAULT   = 4'd0;
  localparam logic [3:0] LT_COMMAND   = 4'd1;
  localparam logic [3:0] LT_HEADER    = 4'd2;
  localparam logic [3:0] LT_COMMENT   = 4'd3;
  localparam logic [3:0] LT_POSITION  = 4'd4;
  localparam logic [3:0] LT_ADDED     = 4'd5;
  localparam logic [3:0] LT_DELETED   = 4'd6;
  localparam logic [3:0] LT_NONL_OLD  = 4'd7;
  localparam logic [3:0] LT_NONL_NEW  = 4'd8;
  localparam logic [3:0] LT_NONL_BOTH = 4'd9;

  localparam int NUM_PFX = 8;
  localparam logic [2:0] PX_DIFF = 3'd0;
  localparam logic [2:0] PX_OLDH = 3'd1;
  localparam logic [2:0] PX_NEWH = 3'd2;
  localparam logic [2:0] PX_HUNK = 3'd3;
  localparam logic [2:0] PX_ADD  = 3'd4;
  localparam logic [2:0] PX_DEL  = 3'd5;
  localparam logic [2:0] PX_CTX  = 3'd6;
  localparam logic [2:0] PX_BSL  = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // prefix characters, padded to eight columns
  localparam logic [7:0] PFX_TEXT [NUM_PFX][8] = '{
    '{8'h64, 8'h69, 8'h66, 8'h66, CH_SPACE, CH_NUL, CH_NUL, CH_NUL},
    '{CH_MINUS, CH_MINUS, CH_MINUS, CH_SPACE, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_PLUS, CH_PLUS, CH_PLUS, CH_SPACE, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_AT, CH_AT, CH_SPACE, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_PLUS, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_MINUS, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_SPACE, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_BSL, CH_SPACE, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
  };

  localparam logic [3:0] PFX_LEN [NUM_PFX] = '{
    4'd5, 4'd4, 4'd4, 4'd3, 4'd1, 4'd1, 4'd1, 4'd2
  };

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [3:0] line_type;
    logic       is_filler;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [FIFO_LVL_W-1:0] level;
    logic                  room;
  } fifo_stat_t;

endpackage

// File: rtl/core/udlc_byte_if.sv
// ---------------------------------------------------------------------------
// udlc_byte_if
// text byte channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface udlc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// File: rtl/core/udlc_line_if.sv
// ---------------------------------------------------------------------------
// udlc_line_if
// classified line channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface udlc_line_if;
  logic       valid;
  logic       ready;
  logic [3:0] line_type;
  logic       is_filler;
  logic       last_of_run;

  modport source (output valid, output line_type, output is_filler, output last_of_run,
                  input ready);
  modport sink (input valid, input line_type, input is_filler, input last_of_run,
                output ready);
endinterface

// File: rtl/core/udlc_parser.sv
// ---------------------------------------------------------------------------
// udlc_parser
// input register, line end detection, prefix matching, hunk header parse and
// line classification; emits up to two results per byte
// ---------------------------------------------------------------------------
module udlc_parser import udlc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_ready,
  input  logic [7:0] text_byte,
  input  fifo_stat_t stat,
  output push_t      push
);

  typedef enum logic [2:0] {
    PS_DIFF, PS_OLDH, PS_NEWH, PS_HUNK, PS_BODY
  } ps_t;

  typedef enum logic [3:0] {
    HS_START, HS_OLD_FIRST1, HS_OLD_MORE1, HS_OLD_FIRST2, HS_OLD_MORE2,
    HS_PLUS, HS_NEW_FIRST1, HS_NEW_MORE1, HS_NEW_FIRST2, HS_NEW_MORE2,
    HS_AT1, HS_AT2, HS_DONE, HS_FAIL
  } hs_t;

  localparam logic [1:0] EOL_NONE = 2'd0;
  localparam logic [1:0] EOL_CR   = 2'd1;
  localparam logic [1:0] EOL_LF   = 2'd2;

  localparam int ACC_W = COUNT_BITS + 4;
  localparam logic [ACC_W-1:0] CMAX_W = {5'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] ONE  = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic [3:0] LEN_MAX = 4'd15;

  logic                   hold_valid;
  logic [7:0]             hold_byte;
  ps_t                    pstate;
  logic [1:0]             pending;
  logic [3:0]             line_len;
  logic [NUM_PFX-1:0]     flags;
  hs_t                    hstep;
  logic [COUNT_BITS-1:0]  hunk_old;
  logic [COUNT_BITS-1:0]  hunk_new;
  logic [COUNT_BITS-1:0]  old_rem;
  logic [COUNT_BITS-1:0]  new_rem;
  logic                   file_added;
  logic                   file_deleted;
  logic [3:0]             prev_type;

  logic                   fire;
  logic [7:0]             b;
  logic [1:0]             code;
  logic                   do_cls;
  logic                   two_eol;
  logic                   is_nul;
  logic [1:0]             eol_len;
  logic                   long_enough;
  logic [NUM_PFX-1:0]     has;
  logic                   body_hit;
  ps_t                    eff_state;
  logic [3:0]             cls_type;
  ps_t                    ps_c;
  logic [COUNT_BITS-1:0]  old_c;
  logic [COUNT_BITS-1:0]  new_c;
  logic                   fa_c;
  logic                   fd_c;
  logic [3:0]             nonl;
  logic                   old_zero;
  logic                   new_zero;
  logic                   old_pos;
  logic                   new_pos;
  logic [3:0]             base_len;
  logic [NUM_PFX-1:0]     base_flags;
  hs_t                    base_hs;
  logic [COUNT_BITS-1:0]  base_ho;
  logic [COUNT_BITS-1:0]  base_hn;
  logic [NUM_PFX-1:0]     flags_f;
  logic [3:0]             len_f;
  hs_t                    hs_f;
  logic [COUNT_BITS-1:0]  ho_f;
  logic [COUNT_BITS-1:0]  hn_f;
  logic                   dig;
  logic [3:0]             dval;
  logic                   new_side;
  logic [ACC_W-1:0]       acc_ext;
  logic [ACC_W-1:0]       acc_sum;
  logic [COUNT_BITS-1:0]  acc_val;
  logic [COUNT_BITS-1:0]  old_dec;
  logic [COUNT_BITS-1:0]  new_dec;

  assign fire       = hold_valid && stat.room;
  assign text_ready = !hold_valid || stat.room;

  assign b       = hold_byte;
  assign code    = (b == CH_CR) ? EOL_CR : ((b == CH_LF) ? EOL_LF : EOL_NONE);
  assign is_nul  = (b == CH_NUL);
  assign do_cls  = (pending != EOL_NONE);
  assign two_eol = do_cls && (code != EOL_NONE) && (code != pending);
  assign eol_len = two_eol ? 2'd2 : 2'd1;
  assign long_enough = ({1'b0, line_len} + {3'b0, eol_len}) >= 5'd10;

  // saturating count arithmetic
  assign old_dec  = (old_rem == CMIN) ? old_rem : old_rem - ONE;
  assign new_dec  = (new_rem == CMIN) ? new_rem : new_rem - ONE;
  assign old_zero = (old_rem == '0);
  assign new_zero = (new_rem == '0);
  assign old_pos  = !old_rem[COUNT_BITS-1] && !old_zero;
  assign new_pos  = !new_rem[COUNT_BITS-1] && !new_zero;

  always_comb begin
    for (int k = 0; k < NUM_PFX; k++) begin
      has[k] = flags[k] && (line_len >= PFX_LEN[k]);
    end
  end

  always_comb begin
    if (file_added) begin
      nonl = LT_NONL_NEW;
    end else if (file_deleted) begin
      nonl = LT_NONL_OLD;
    end else if (old_zero && new_pos) begin
      nonl = LT_NONL_OLD;
    end else if (new_zero && old_pos) begin
      nonl = LT_NONL_NEW;
    end else if (old_zero && new_zero && prev_type == LT_ADDED) begin
      nonl = LT_NONL_NEW;
    end else if (old_zero && new_zero && prev_type == LT_DELETED) begin
      nonl = LT_NONL_OLD;
    end else if (old_zero && new_zero && prev_type == LT_DEFAULT) begin
      nonl = LT_NONL_BOTH;
    end else begin
      nonl = LT_DEFAULT;
    end
  end

  // body lines that match nothing are looked at again from an earlier state
  assign body_hit = has[PX_ADD] || has[PX_DEL] || has[PX_CTX] || (long_enough && has[PX_BSL]);

  always_comb begin
    if (pstate == PS_BODY && !body_hit) begin
      eff_state = has[PX_HUNK] ? PS_HUNK : PS_DIFF;
    end else begin
      eff_state = pstate;
    end
  end

  always_comb begin
    cls_type = LT_DEFAULT;
    ps_c     = eff_state;
    old_c    = old_rem;
    new_c    = new_rem;
    fa_c     = file_added;
    fd_c     = file_deleted;
    unique case (eff_state)
      PS_DIFF: begin
        if (has[PX_DIFF]) begin
          cls_type = LT_COMMAND;
          ps_c     = PS_OLDH;
        end
      end
      PS_OLDH: begin
        if (has[PX_OLDH]) begin
          cls_type = LT_HEADER;
          ps_c     = PS_NEWH;
        end else begin
          cls_type = LT_COMMENT;
        end
      end
      PS_NEWH: begin
        if (has[PX_NEWH]) begin
          cls_type = LT_HEADER;
          ps_c     = PS_HUNK;
        end
      end
      PS_HUNK: begin
        if (has[PX_HUNK] && hstep == HS_DONE) begin
          cls_type = LT_POSITION;
          old_c    = hunk_old;
          new_c    = hunk_new;
          fa_c     = (hunk_old == '0);
          fd_c     = (hunk_new == '0);
          ps_c     = PS_BODY;
        end
      end
      PS_BODY: begin
        if (has[PX_ADD]) begin
          new_c    = new_dec;
          cls_type = LT_ADDED;
        end else if (has[PX_DEL]) begin
          old_c    = old_dec;
          cls_type = LT_DELETED;
        end else if (has[PX_CTX]) begin
          old_c    = old_dec;
          new_c    = new_dec;
          cls_type = LT_DEFAULT;
        end else begin
          cls_type = nonl;
        end
      end
      default: begin
        ps_c = PS_DIFF;
      end
    endcase
  end

  // line state the byte is fed into: cleared when a line was just closed
  assign base_len   = do_cls ? 4'd0 : line_len;
  assign base_flags = do_cls ? '1 : flags;
  assign base_hs    = do_cls ? HS_START : hstep;
  assign base_ho    = do_cls ? '0 : hunk_old;
  assign base_hn    = do_cls ? '0 : hunk_new;

  always_comb begin
    for (int k = 0; k < NUM_PFX; k++) begin
      flags_f[k] = base_flags[k];
      if (base_len < PFX_LEN[k] && b != PFX_TEXT[k][base_len[2:0]]) begin
        flags_f[k] = 1'b0;
      end
    end
  end

  assign len_f = (base_len < LEN_MAX) ? base_len + 4'd1 : base_len;

  assign dig      = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval     = dig ? 4'(b - CH_ZERO) : 4'd0;
  assign new_side = (base_hs == HS_NEW_FIRST1) || (base_hs == HS_NEW_MORE1) ||
                    (base_hs == HS_NEW_FIRST2) || (base_hs == HS_NEW_MORE2);
  assign acc_ext  = {4'b0, (new_side ? base_hn : base_ho)};
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {{(ACC_W-4){1'b0}}, dval};
  assign acc_val  = (acc_sum > CMAX_W) ? CMAX : acc_sum[COUNT_BITS-1:0];

  always_comb begin
    hs_f = HS_FAIL;
    ho_f = base_ho;
    hn_f = base_hn;
    if (base_len >= 4'd3) begin
      unique case (base_hs)
        HS_START: begin
          if (b == CH_MINUS) hs_f = HS_OLD_FIRST1;
        end
        HS_OLD_FIRST1, HS_OLD_FIRST2: begin
          if (dig) begin
            ho_f = acc_val;
            hs_f = (base_hs == HS_OLD_FIRST1) ? HS_OLD_MORE1 : HS_OLD_MORE2;
          end
        end
        HS_OLD_MORE1, HS_OLD_MORE2: begin
          if (dig) begin
            ho_f = acc_val;
            hs_f = base_hs;
          end else if (b == CH_COMMA && base_hs == HS_OLD_MORE1) begin
            ho_f = '0;
            hs_f = HS_OLD_FIRST2;
          end else if (b == CH_SPACE) begin
            hs_f = HS_PLUS;
          end
        end
        HS_PLUS: begin
          if (b == CH_PLUS) hs_f = HS_NEW_FIRST1;
        end
        HS_NEW_FIRST1, HS_NEW_FIRST2: begin
          if (dig) begin
            hn_f = acc_val;
            hs_f = (base_hs == HS_NEW_FIRST1) ? HS_NEW_MORE1 : HS_NEW_MORE2;
          end
        end
        HS_NEW_MORE1, HS_NEW_MORE2: begin
          if (dig) begin
            hn_f = acc_val;
            hs_f = base_hs;
          end else if (b == CH_COMMA && base_hs == HS_NEW_MORE1) begin
            hn_f = '0;
            hs_f = HS_NEW_FIRST2;
          end else if (b == CH_SPACE) begin
            hs_f = HS_AT1;
          end
        end
        HS_AT1: begin
          if (b == CH_AT) hs_f = HS_AT2;
        end
        HS_AT2: begin
          if (b == CH_AT) hs_f = HS_DONE;
        end
        HS_DONE: begin
          hs_f = HS_DONE;
        end
        default: begin
          hs_f = HS_FAIL;
        end
      endcase
    end else begin
      hs_f = base_hs;
    end
  end

  // results of this byte: the closed line, then the filler at end of text
  always_comb begin
    push.count              = fire ? ({1'b0, do_cls} + {1'b0, is_nul}) : 2'd0;
    push.second.line_type   = LT_DEFAULT;
    push.second.is_filler   = 1'b1;
    push.second.last_of_run = 1'b1;
    if (do_cls) begin
      push.first.line_type   = cls_type;
      push.first.is_filler   = 1'b0;
      push.first.last_of_run = !is_nul;
    end else begin
      push.first.line_type   = LT_DEFAULT;
      push.first.is_filler   = 1'b1;
      push.first.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      pstate       <= PS_DIFF;
      pending      <= EOL_NONE;
      line_len     <= 4'd0;
      flags        <= '1;
      hstep        <= HS_START;
      hunk_old     <= '0;
      hunk_new     <= '0;
      old_rem      <= '0;
      new_rem      <= '0;
      file_added   <= 1'b0;
      file_deleted <= 1'b0;
      prev_type    <= LT_DEFAULT;
    end else begin
      if (text_valid && text_ready) begin
        hold_valid <= 1'b1;
        hold_byte  <= text_byte;
      end else if (fire) begin
        hold_valid <= 1'b0;
      end
      if (fire) begin
        if (is_nul) begin
          pstate       <= PS_DIFF;
          pending      <= EOL_NONE;
          line_len     <= 4'd0;
          flags        <= '1;
          hstep        <= HS_START;
          hunk_old     <= '0;
          hunk_new     <= '0;
          old_rem      <= '0;
          new_rem      <= '0;
          file_added   <= 1'b0;
          file_deleted <= 1'b0;
          prev_type    <= LT_DEFAULT;
        end else begin
          if (do_cls) begin
            pstate       <= ps_c;
            old_rem      <= old_c;
            new_rem      <= new_c;
            file_added   <= fa_c;
            file_deleted <= fd_c;
            prev_type    <= cls_type;
          end
          pending <= two_eol ? EOL_NONE : code;
          if (code != EOL_NONE) begin
            line_len <= base_len;
            flags    <= base_flags;
            hstep    <= base_hs;
            hunk_old <= base_ho;
            hunk_new <= base_hn;
          end else begin
            line_len <= len_f;
            flags    <= flags_f;
            hstep    <= hs_f;
            hunk_old <= ho_f;
            hunk_new <= hn_f;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/udlc_out_fifo.sv
// ---------------------------------------------------------------------------
// udlc_out_fifo
// four-word result queue, takes up to two words a cycle, gives one
// ---------------------------------------------------------------------------
module udlc_out_fifo import udlc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output fifo_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_word
);

  result_t               slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_LVL_W-1:0] level;
  logic                  pop;

  assign out_valid  = (level != '0);
  assign out_word   = slots[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign stat.level = level;
  assign stat.room  = (level <= FIFO_LVL_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      level  <= level + FIFO_LVL_W'(push.count) - FIFO_LVL_W'(pop);
    end
  end

endmodule

// File: rtl/core/unified_diff_line_classifier.sv
// ---------------------------------------------------------------------------
// unified_diff_line_classifier
// classifies the lines of unified diff text arriving one byte a cycle
// ---------------------------------------------------------------------------
// text_in carries one text byte per word; a zero byte ends the document.
// line_out carries one word per finished line: line_type, is_filler and
// last_of_run, the latter set on the last word caused by one byte.
// a line's word is caused by the byte after its first line-end byte; at the
// zero byte the pending line, then one filler line, are given, and the
// parser returns to its reset state for the next document.
// throughput: one byte per cycle while the buffer has room, set by the
// single-pass parser stage; a byte that causes two words pushes both at once.
// a byte is registered in the input register at acceptance and parsed once
// the buffer has room; its words are written to the buffer, then offered on line_out.
// words queue in a four-word buffer; when the receiver stalls, bytes are
// still taken until the buffer holds three or more words and a byte waits
// in the input register, then text_in.ready drops.
// rst (synchronous) empties the buffer and clears all parser state.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module unified_diff_line_classifier import udlc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input logic          clk,
  input logic          rst,
  udlc_byte_if.sink    text_in,
  udlc_line_if.source  line_out
);

  push_t      push;
  fifo_stat_t stat;
  result_t    out_word;

  udlc_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_in.valid),
    .text_ready (text_in.ready),
    .text_byte  (text_in.text_byte),
    .stat       (stat),
    .push       (push)
  );

  udlc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .stat      (stat),
    .out_valid (line_out.valid),
    .out_ready (line_out.ready),
    .out_word  (out_word)
  );

  assign line_out.line_type   = out_word.line_type;
  assign line_out.is_filler   = out_word.is_filler;
  assign line_out.last_of_run = out_word.last_of_run;

  `ASSERT_ALWAYS(a_level_max, clk, rst, stat.level <= FIFO_LVL_W'(FIFO_DEPTH), "buffer overfill")
  `ASSERT_IMPLIES(a_push_room, clk, rst, push.count != 2'd0, stat.room, "push without room")
  `ASSERT_IMPLIES(a_pair_order, clk, rst, push.count == 2'd2, push.second.is_filler && !push.first.last_of_run, "bad word pair")
  `ASSERT_IMPLIES(a_filler_last, clk, rst, line_out.valid && line_out.is_filler, line_out.last_of_run, "filler not last")

endmodule

// File: bench/diff_line_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diff_line_checker
// watches the text and line channels, predicts the type of every finished
// line from the accepted bytes and compares each line word in order
// ---------------------------------------------------------------------------
module diff_line_checker import udlc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic  clk,
  input  logic  rst,
  udlc_byte_if  text_mon,
  udlc_line_if  line_mon,
  output int    errors,
  output int    owed,
  output int    checked
);

  localparam longint CNT_MAX = (longint'(1) << (COUNT_BITS - 1)) - 1;
  localparam longint CNT_MIN = -CNT_MAX - 1;
  localparam int NONL_MIN_LEN = 10;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    PS_SEEK_DIFF, PS_SEEK_OLDH, PS_SEEK_NEWH, PS_SEEK_HUNK, PS_BODY
  } parse_state_e;

  typedef enum logic [1:0] {EOL_NONE, EOL_CR, EOL_LF} eol_e;

  typedef enum logic [3:0] {
    HS_DASH, HS_OLD_A1, HS_OLD_A, HS_OLD_B1, HS_OLD_B, HS_PLUS,
    HS_NEW_A1, HS_NEW_A, HS_NEW_B1, HS_NEW_B, HS_AT1, HS_AT2, HS_DONE, HS_FAIL
  } hunk_step_e;

  parse_state_e pstate;
  eol_e         eol_wait;
  logic [3:0]   line_len;
  logic [7:0]   pfx_live;
  hunk_step_e   hstep;
  longint       hdr_old;
  longint       hdr_new;
  longint       old_left;
  longint       new_left;
  bit           file_new;
  bit           file_gone;
  logic [3:0]   prev_type;

  result_t types_due [$];
  result_t want;

  function automatic void clear_line();
    line_len = '0;
    pfx_live = '1;
    hstep = HS_DASH;
    hdr_old = 0;
    hdr_new = 0;
  endfunction

  function automatic void clear_all();
    pstate = PS_SEEK_DIFF;
    eol_wait = EOL_NONE;
    old_left = 0;
    new_left = 0;
    file_new = 1'b0;
    file_gone = 1'b0;
    prev_type = LT_DEFAULT;
    clear_line();
  endfunction

  function automatic longint add_digit(input longint v, input longint d);
    if (v > (CNT_MAX - d) / 10) return CNT_MAX;
    return v * 10 + d;
  endfunction

  function automatic longint dec_sat(input longint v);
    return (v > CNT_MIN) ? v - 1 : v;
  endfunction

  // hunk header: -[a,]b +[c,]d @@
  function automatic void feed_hunk(input logic [7:0] b);
    bit dig;
    longint d;
    hunk_step_e nx;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    d = longint'(b) - longint'(CH_ZERO);
    nx = HS_FAIL;
    case (hstep)
      HS_DASH: if (b == CH_MINUS) nx = HS_OLD_A1;
      HS_OLD_A1: if (dig) begin
        hdr_old = add_digit(hdr_old, d);
        nx = HS_OLD_A;
      end
      HS_OLD_B1: if (dig) begin
        hdr_old = add_digit(hdr_old, d);
        nx = HS_OLD_B;
      end
      HS_OLD_A: if (dig) begin
        hdr_old = add_digit(hdr_old, d);
        nx = HS_OLD_A;
      end else if (b == CH_COMMA) begin
        hdr_old = 0;
        nx = HS_OLD_B1;
      end else if (b == CH_SPACE) begin
        nx = HS_PLUS;
      end
      HS_OLD_B: if (dig) begin
        hdr_old = add_digit(hdr_old, d);
        nx = HS_OLD_B;
      end else if (b == CH_SPACE) begin
        nx = HS_PLUS;
      end
      HS_PLUS: if (b == CH_PLUS) nx = HS_NEW_A1;
      HS_NEW_A1: if (dig) begin
        hdr_new = add_digit(hdr_new, d);
        nx = HS_NEW_A;
      end
      HS_NEW_B1: if (dig) begin
        hdr_new = add_digit(hdr_new, d);
        nx = HS_NEW_B;
      end
      HS_NEW_A: if (dig) begin
        hdr_new = add_digit(hdr_new, d);
        nx = HS_NEW_A;
      end else if (b == CH_COMMA) begin
        hdr_new = 0;
        nx = HS_NEW_B1;
      end else if (b == CH_SPACE) begin
        nx = HS_AT1;
      end
      HS_NEW_B: if (dig) begin
        hdr_new = add_digit(hdr_new, d);
        nx = HS_NEW_B;
      end else if (b == CH_SPACE) begin
        nx = HS_AT1;
      end
      HS_AT1: if (b == CH_AT) nx = HS_AT2;
      HS_AT2: if (b == CH_AT) nx = HS_DONE;
      HS_DONE: nx = HS_DONE;
      default: nx = HS_FAIL;
    endcase
    hstep = nx;
  endfunction

  function automatic void feed_line(input logic [7:0] b);
    logic [3:0] pos;
    pos = line_len;
    for (int k = 0; k < NUM_PFX; k++) begin
      if (pos < PFX_LEN[k] && b != PFX_TEXT[k][pos[2:0]]) pfx_live[k] = 1'b0;
    end
    if (pos >= PFX_LEN[PX_HUNK]) feed_hunk(b);
    if (pos != 4'hF) line_len = pos + 4'd1;
  endfunction

  function automatic bit has_pfx(input int k);
    return pfx_live[k] && (line_len >= PFX_LEN[k]);
  endfunction

  function automatic logic [3:0] nonl_kind();
    if (file_new) return LT_NONL_NEW;
    if (file_gone) return LT_NONL_OLD;
    if (old_left == 0 && new_left > 0) return LT_NONL_OLD;
    if (new_left == 0 && old_left > 0) return LT_NONL_NEW;
    if (old_left == 0 && new_left == 0) begin
      if (prev_type == LT_ADDED) return LT_NONL_NEW;
      if (prev_type == LT_DELETED) return LT_NONL_OLD;
      if (prev_type == LT_DEFAULT) return LT_NONL_BOTH;
    end
    return LT_DEFAULT;
  endfunction

  function automatic logic [3:0] classify_line(input int eol_len);
    logic [3:0] t;
    bit again;
    bit long_line;
    t = LT_DEFAULT;
    again = 1'b1;
    long_line = (int'(line_len) + eol_len) >= NONL_MIN_LEN;
    while (again) begin
      again = 1'b0;
      case (pstate)
        PS_SEEK_DIFF: if (has_pfx(PX_DIFF)) begin
          t = LT_COMMAND;
          pstate = PS_SEEK_OLDH;
        end
        PS_SEEK_OLDH: if (has_pfx(PX_OLDH)) begin
          t = LT_HEADER;
          pstate = PS_SEEK_NEWH;
        end else begin
          t = LT_COMMENT;
        end
        PS_SEEK_NEWH: if (has_pfx(PX_NEWH)) begin
          t = LT_HEADER;
          pstate = PS_SEEK_HUNK;
        end
        PS_SEEK_HUNK: if (has_pfx(PX_HUNK) && hstep == HS_DONE) begin
          old_left = hdr_old;
          new_left = hdr_new;
          t = LT_POSITION;
          file_new = (old_left == 0);
          file_gone = (new_left == 0);
          pstate = PS_BODY;
        end
        PS_BODY: if (has_pfx(PX_ADD)) begin
          new_left = dec_sat(new_left);
          t = LT_ADDED;
        end else if (has_pfx(PX_DEL)) begin
          old_left = dec_sat(old_left);
          t = LT_DELETED;
        end else if (has_pfx(PX_CTX)) begin
          old_left = dec_sat(old_left);
          new_left = dec_sat(new_left);
          t = LT_DEFAULT;
        end else if (long_line && has_pfx(PX_BSL)) begin
          t = nonl_kind();
        end else if (has_pfx(PX_HUNK)) begin
          pstate = PS_SEEK_HUNK;
          again = 1'b1;
        end else begin
          pstate = PS_SEEK_DIFF;
          again = 1'b1;
        end
        default: pstate = PS_SEEK_DIFF;
      endcase
    end
    prev_type = t;
    clear_line();
    return t;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    result_t got [2];
    int n;
    bit paired;
    eol_e code;
    n = 0;
    paired = 1'b0;
    code = (b == CH_CR) ? EOL_CR : ((b == CH_LF) ? EOL_LF : EOL_NONE);
    if (eol_wait != EOL_NONE) begin
      if (code != EOL_NONE && code != eol_wait) begin
        eol_wait = EOL_NONE;
        got[0] = '{line_type: classify_line(2), is_filler: 1'b0, last_of_run: 1'b0};
        n = 1;
        paired = 1'b1;
      end else begin
        eol_wait = EOL_NONE;
        got[0] = '{line_type: classify_line(1), is_filler: 1'b0, last_of_run: 1'b0};
        n = 1;
      end
    end
    if (!paired) begin
      if (b == CH_NUL) begin
        got[n] = '{line_type: LT_DEFAULT, is_filler: 1'b1, last_of_run: 1'b0};
        n++;
        clear_all();
      end else if (code != EOL_NONE) begin
        eol_wait = code;
      end else begin
        feed_line(b);
      end
    end
    for (int i = 0; i < n; i++) begin
      got[i].last_of_run = (i == n - 1);
      types_due.push_back(got[i]);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_all();
      types_due.delete();
    end else begin
      if (line_mon.valid && line_mon.ready) begin
        if (types_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected line word: type %0d filler %0b last %0b",
                     line_mon.line_type, line_mon.is_filler, line_mon.last_of_run);
        end else begin
          want = types_due.pop_front();
          if (line_mon.line_type !== want.line_type || line_mon.is_filler !== want.is_filler ||
              line_mon.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("line word %0d: expected type %0d filler %0b last %0b, got type %0d filler %0b last %0b",
                       checked, want.line_type, want.is_filler, want.last_of_run,
                       line_mon.line_type, line_mon.is_filler, line_mon.last_of_run);
          end
          checked++;
        end
      end
      if (text_mon.valid && text_mon.ready) predict_byte(text_mon.text_byte);
    end
    owed <= types_due.size();
  end

endmodule

// File: bench/unified_diff_line_classifier_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unified_diff_line_classifier_tb
// feeds directed line-end cases and then random diff documents, mostly
// well formed with random content, with random stalls on both channels;
// the checker predicts and compares every line word
// ---------------------------------------------------------------------------
module unified_diff_line_classifier_tb;
  import udlc_pkg::*;

  localparam int COUNT_BITS = 32;
  localparam int CLK_PERIOD = 10;
  localparam int BYTE_TARGET = 1050;
  localparam int MAX_WAIT = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst;

  udlc_byte_if text_ch ();
  udlc_line_if line_ch ();

  int errors;
  int owed;
  int checked;
  int bytes_sent;
  int docs_sent;
  int idle_cycles;
  int unsigned sink_wait;
  int unsigned sink_stall;
  bit src_burst;
  bit sink_burst;

  logic [7:0] line_end_cases [$] = '{
    8'hFF, CH_CR, CH_LF, 8'h01, CH_LF, CH_CR, CH_LF, CH_LF, CH_CR, CH_CR,
    8'h80, 8'h7F, CH_NUL, CH_NUL
  };

  unified_diff_line_classifier #(.COUNT_BITS(COUNT_BITS)) u_dut (
    .clk(clk),
    .rst(rst),
    .text_in(text_ch),
    .line_out(line_ch)
  );

  diff_line_checker #(.COUNT_BITS(COUNT_BITS)) u_chk (
    .clk(clk),
    .rst(rst),
    .text_mon(text_ch),
    .line_mon(line_ch),
    .errors(errors),
    .owed(owed),
    .checked(checked)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      line_ch.ready <= 1'b0;
      sink_wait <= 0;
    end else if (line_ch.valid && line_ch.ready) begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      sink_stall = draw_wait(sink_burst);
      sink_wait <= sink_stall;
      line_ch.ready <= (sink_stall == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      line_ch.ready <= (sink_wait == 1);
    end else begin
      line_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (line_ch.valid && line_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = draw_wait(src_burst);
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
    if (b == CH_NUL) docs_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_eol();
    case ($urandom_range(0, 5))
      0: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      1: begin
        send_byte(CH_LF);
        send_byte(CH_CR);
      end
      2: send_byte(CH_CR);
      default: send_byte(CH_LF);
    endcase
  endtask

  // printable text, now and then any nonzero byte
  task automatic send_junk(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(1, 255));
      else b = 8'($urandom_range(32, 126));
      send_byte(b);
    end
  endtask

  function automatic string count_text();
    longint top_count;
    top_count = (longint'(1) << (COUNT_BITS - 1)) - 1;
    case ($urandom_range(0, 9))
      0, 1: return "0";
      2: return $sformatf("%0d%0d", $urandom, $urandom);
      3: return $sformatf("%0d", top_count);
      4: return $sformatf("%0d", top_count + 1);
      default: return $sformatf("%0d", $urandom_range(0, 4));
    endcase
  endfunction

  task automatic send_hunk_header();
    string s;
    s = "@@ -";
    if ($urandom_range(0, 2) != 0) s = {s, count_text(), ","};
    s = {s, count_text(), " +"};
    if ($urandom_range(0, 2) != 0) s = {s, count_text(), ","};
    s = {s, count_text(), " @@"};
    // broken header
    if ($urandom_range(0, 7) == 0) s = s.substr(0, $urandom_range(1, s.len() - 2));
    send_str(s);
    if ($urandom_range(0, 1) != 0) send_junk($urandom_range(0, 10));
    send_eol();
  endtask

  task automatic send_body_line();
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        send_byte(CH_PLUS);
        send_junk($urandom_range(0, 12));
      end
      3, 4, 5: begin
        send_byte(CH_MINUS);
        send_junk($urandom_range(0, 12));
      end
      6, 7: begin
        send_byte(CH_SPACE);
        send_junk($urandom_range(0, 12));
      end
      8: send_str("\\ No newline at end of file");
      9: begin
        send_str("\\ ");
        send_junk($urandom_range(0, 9));
      end
      10: begin
        send_byte(CH_BSL);
        send_junk($urandom_range(0, 12));
      end
      default: send_junk($urandom_range(0, 15));
    endcase
    send_eol();
  endtask

  task automatic send_document();
    if ($urandom_range(0, 9) == 0) begin
      send_junk($urandom_range(1, 60));
    end else begin
      repeat ($urandom_range(0, 1)) begin
        send_junk($urandom_range(0, 12));
        send_eol();
      end
      repeat ($urandom_range(1, 3)) begin
        send_str("diff ");
        send_junk($urandom_range(0, 14));
        send_eol();
        repeat ($urandom_range(0, 2)) begin
          send_junk($urandom_range(0, 14));
          send_eol();
        end
        if ($urandom_range(0, 7) != 0) begin
          send_str("--- ");
          send_junk($urandom_range(0, 10));
          send_eol();
        end
        if ($urandom_range(0, 7) != 0) begin
          send_str("+++ ");
          send_junk($urandom_range(0, 10));
          send_eol();
        end
        repeat ($urandom_range(1, 3)) begin
          send_hunk_header();
          repeat ($urandom_range(0, 6)) send_body_line();
        end
      end
    end
    // unterminated tail
    if ($urandom_range(0, 3) == 0) send_junk($urandom_range(1, 5));
    send_byte(CH_NUL);
  endtask

  initial begin
    rst <= 1'b1;
    text_ch.valid <= 1'b0;
    text_ch.text_byte <= CH_NUL;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (line_end_cases[i]) send_byte(line_end_cases[i]);
    send_str("diff ");
    send_byte(CH_LF);
    send_byte(CH_NUL);

    while (bytes_sent < BYTE_TARGET) send_document();
    text_ch.valid <= 1'b0;

    // let the count of owed words catch up with the last byte
    repeat (2) @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d text bytes in %0d documents: line-end cases, then random diffs",
             bytes_sent, docs_sent);
    $display("compared %0d line words, %0d mismatches, %0d still owed", checked, errors, owed);
    if (errors == 0 && owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
